// File: rtl/ectc_pkg.sv
// Shared types, constants and the month table for the epoch-to-calendar pipeline.
package ectc_pkg;

    // Reciprocal multipliers: floor(2^S / d), quotient estimate is exact or one low.
    localparam logic [30:0] DIV15_M30   = 31'd1145324612; // /15 on 30-bit x, S = 34
    localparam logic [24:0] DIV15_M25   = 25'd17895697;   // /15 on 25-bit x, S = 28
    localparam logic [18:0] DIV3_M18    = 19'd349525;     // /3 on 18-bit x, S = 20
    localparam logic [16:0] DIV7_M16    = 17'd74898;      // /7 on 16-bit x, S = 19
    localparam logic [18:0] DIV1461_M18 = 19'd367468;     // /1461 on 18-bit x, S = 29

    localparam logic [6:0]  SECS_PER_MIN  = 7'd60;
    localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
    localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;
    localparam logic [17:0] DAYS_PER_QUAD = 18'd1461;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [8:0]  LEAP_DAY_DOY  = 9'd60;
    localparam logic [4:0]  LEAP_DAY_DOM  = 5'd29;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

    // Stage handoff: time of day plus whole days.
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [15:0] days;
    } t_time_split;

    // Stage handoff: weekday, year and day of year.
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [2:0] wd;
        logic [7:0] yr;
        logic [8:0] doy;
        logic       leap;
    } t_date_split;

    // Last day of year of month idx in a common year; idx 0 gives 0.
    function automatic logic [8:0] month_end(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/ectc_time_split.sv
// Six-stage split of seconds into second, minute, hour and day count.
module ectc_time_split
    import ectc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_local_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output t_time_split o_data
);

    logic [5:0]  r_v;
    logic [5:0]  w_en;

    logic [31:0] r_s1_t;
    logic [26:0] r_s1_qe;
    logic [26:0] r_s2_m;
    logic [5:0]  r_s2_sec;
    logic [26:0] r_s3_m;
    logic [20:0] r_s3_qe;
    logic [5:0]  r_s3_sec;
    logic [20:0] r_s4_h;
    logic [5:0]  r_s4_sec;
    logic [5:0]  r_s4_min;
    logic [20:0] r_s5_h;
    logic [15:0] r_s5_qe;
    logic [5:0]  r_s5_sec;
    logic [5:0]  r_s5_min;
    logic [5:0]  r_s6_sec;
    logic [5:0]  r_s6_min;
    logic [4:0]  r_s6_hr;
    logic [15:0] r_s6_days;

    logic [60:0] w_p1;
    logic [31:0] w_rem2;
    logic [48:0] w_p3;
    logic [26:0] w_rem4;
    logic [35:0] w_p5;
    logic [20:0] w_rem6;

    // stage advances when empty or when the next one advances
    always_comb begin
        w_en[5] = !r_v[5] || i_ready;
        for (int k = 4; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < 6; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // t/60 = (t>>2)/15
    assign w_p1   = 61'(i_local_seconds[31:2]) * 61'(DIV15_M30);
    assign w_rem2 = r_s1_t - (32'({r_s1_qe, 6'b0}) - 32'({r_s1_qe, 2'b0}));
    assign w_p3   = 49'(r_s2_m[26:2]) * 49'(DIV15_M25);
    assign w_rem4 = r_s3_m - ({r_s3_qe, 6'b0} - 27'({r_s3_qe, 2'b0}));
    // h/24 = (h>>3)/3
    assign w_p5   = 36'(r_s4_h[20:3]) * 36'(DIV3_M18);
    assign w_rem6 = r_s5_h - (21'({r_s5_qe, 4'b0}) + 21'({r_s5_qe, 3'b0}));

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_t  <= i_local_seconds;
            r_s1_qe <= w_p1[60:34];
        end
        if (w_en[1]) begin
            if (w_rem2 >= 32'(SECS_PER_MIN)) begin
                r_s2_m   <= r_s1_qe + 27'd1;
                r_s2_sec <= 6'(w_rem2 - 32'(SECS_PER_MIN));
            end else begin
                r_s2_m   <= r_s1_qe;
                r_s2_sec <= w_rem2[5:0];
            end
        end
        if (w_en[2]) begin
            r_s3_m   <= r_s2_m;
            r_s3_qe  <= w_p3[48:28];
            r_s3_sec <= r_s2_sec;
        end
        if (w_en[3]) begin
            r_s4_sec <= r_s3_sec;
            if (w_rem4 >= 27'(SECS_PER_MIN)) begin
                r_s4_h   <= r_s3_qe + 21'd1;
                r_s4_min <= 6'(w_rem4 - 27'(SECS_PER_MIN));
            end else begin
                r_s4_h   <= r_s3_qe;
                r_s4_min <= w_rem4[5:0];
            end
        end
        if (w_en[4]) begin
            r_s5_h   <= r_s4_h;
            r_s5_qe  <= w_p5[35:20];
            r_s5_sec <= r_s4_sec;
            r_s5_min <= r_s4_min;
        end
        if (w_en[5]) begin
            r_s6_sec <= r_s5_sec;
            r_s6_min <= r_s5_min;
            if (w_rem6 >= 21'(HOURS_PER_DAY)) begin
                r_s6_days <= r_s5_qe + 16'd1;
                r_s6_hr   <= 5'(w_rem6 - 21'(HOURS_PER_DAY));
            end else begin
                r_s6_days <= r_s5_qe;
                r_s6_hr   <= w_rem6[4:0];
            end
        end
    end

    assign o_data.sec  = r_s6_sec;
    assign o_data.min  = r_s6_min;
    assign o_data.hr   = r_s6_hr;
    assign o_data.days = r_s6_days;

endmodule

// File: rtl/ectc_date_split.sv
// Three-stage split of the day count into weekday, year and day of year.
module ectc_date_split
    import ectc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_time_split i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_date_split o_data
);

    logic [2:0]  r_v;
    logic [2:0]  w_en;

    t_time_split r_s7_tm;
    logic [12:0] r_s7_wqe;
    logic [7:0]  r_s7_yqe;
    t_time_split r_s8_tm;
    logic [2:0]  r_s8_wd;
    logic [7:0]  r_s8_yr;
    t_date_split r_s9;

    logic [32:0] w_wp;
    logic [36:0] w_yp;
    logic [15:0] w_wrem;
    logic [17:0] w_days4;
    logic [17:0] w_yrem;
    logic [2:0]  w_wd;
    logic [15:0] w_y365;
    logic [8:0]  w_ceil4;
    logic [15:0] w_doy;

    always_comb begin
        w_en[2] = !r_v[2] || i_ready;
        w_en[1] = !r_v[1] || w_en[2];
        w_en[0] = !r_v[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
        end
    end

    assign w_wp = 33'(i_data.days) * 33'(DIV7_M16);
    assign w_yp = 37'({i_data.days, 2'b0}) * 37'(DIV1461_M18);

    // weekday and year corrections
    assign w_wrem  = r_s7_tm.days - ({r_s7_wqe, 3'b0} - 16'(r_s7_wqe));
    assign w_days4 = {r_s7_tm.days, 2'b0};
    assign w_yrem  = w_days4 - 18'(r_s7_yqe) * DAYS_PER_QUAD;

    always_comb begin
        if (w_wrem >= 16'(DAYS_PER_WEEK)) begin
            w_wd = 3'(w_wrem - 16'(DAYS_PER_WEEK));
        end else begin
            w_wd = w_wrem[2:0];
        end
        if (w_wd == 3'd0) begin
            w_wd = 3'(DAYS_PER_WEEK);
        end
    end

    // doy = days - (365*yr + ceil(yr/4)) + 1
    assign w_y365  = 16'(r_s8_yr) * DAYS_PER_YEAR;
    assign w_ceil4 = (9'(r_s8_yr) + 9'd3) >> 2;
    assign w_doy   = r_s8_tm.days - w_y365 - 16'(w_ceil4) + 16'd1;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s7_tm  <= i_data;
            r_s7_wqe <= w_wp[31:19];
            r_s7_yqe <= w_yp[36:29];
        end
        if (w_en[1]) begin
            r_s8_tm <= r_s7_tm;
            r_s8_wd <= w_wd;
            if (w_yrem >= DAYS_PER_QUAD) begin
                r_s8_yr <= r_s7_yqe + 8'd1;
            end else begin
                r_s8_yr <= r_s7_yqe;
            end
        end
        if (w_en[2]) begin
            r_s9.sec  <= r_s8_tm.sec;
            r_s9.min  <= r_s8_tm.min;
            r_s9.hr   <= r_s8_tm.hr;
            r_s9.wd   <= r_s8_wd;
            r_s9.yr   <= r_s8_yr;
            r_s9.doy  <= w_doy[8:0];
            r_s9.leap <= (r_s8_yr[1:0] == 2'b00);
        end
    end

    assign o_data = r_s9;

endmodule

// File: rtl/ectc_month_map.sv
// Month lookup from day of year, with the output register.
module ectc_month_map
    import ectc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_date_split i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [7:0]  o_year
);

    logic       r_v;
    logic       w_en;
    logic [8:0] w_d;
    logic [3:0] w_cnt;
    logic [8:0] w_dom;
    logic [3:0] w_mon;
    logic [4:0] w_day;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    // after leap day, fold back onto the common-year table
    assign w_d = (i_data.leap && (i_data.doy > LEAP_DAY_DOY)) ? i_data.doy - 9'd1
                                                              : i_data.doy;

    always_comb begin
        w_cnt = 4'd0;
        for (int k = 1; k < 12; k++) begin
            w_cnt = w_cnt + 4'(w_d > month_end(4'(k)));
        end
        w_dom = w_d - month_end(w_cnt);
        if (i_data.leap && (i_data.doy == LEAP_DAY_DOY)) begin
            w_mon = MONTH_FEB;
            w_day = LEAP_DAY_DOM;
        end else begin
            w_mon = w_cnt + 4'd1;
            w_day = w_dom[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_second       <= i_data.sec;
            o_minute       <= i_data.min;
            o_hour         <= i_data.hr;
            o_weekday      <= i_data.wd;
            o_day_of_month <= w_day;
            o_month        <= w_mon;
            o_year         <= i_data.yr;
        end
    end

endmodule

// File: rtl/epoch_seconds_to_calendar_unit.sv
// Stages: 6 time, 3 date, 1 month, from input transaction to o_out_valid.
// Throughput: one transaction per cycle unless i_out_ready stalls; each stage holds one item and a stalled
// stage is refilled as soon as its successor moves, so bubbles are squeezed out.
// Each of the five reciprocal multiplies is followed by a register.
// Reset: synchronous, active low on i_rst_n; clears every stage valid bit, data is not reset.
// o_in_ready depends combinationally on i_out_ready through the stage enable chain.
module epoch_seconds_to_calendar_unit
    import ectc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_local_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [7:0]  o_year
);

    // time split -> date split handoff
    logic        w_tm_valid;
    logic        w_tm_ready;
    t_time_split w_tm;

    // date split -> month map handoff
    logic        w_dt_valid;
    logic        w_dt_ready;
    t_date_split w_dt;

    // Seconds -> (sec, min, hr, days): three divide-by-constant steps,
    // each a reciprocal multiply stage then a correct-by-one stage.
    ectc_time_split u_time_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_local_seconds (i_local_seconds),
        .o_valid         (w_tm_valid),
        .i_ready         (w_tm_ready),
        .o_data          (w_tm)
    );

    // Days -> weekday and year in parallel, then day of year.
    ectc_date_split u_date_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tm_valid),
        .o_ready (w_tm_ready),
        .i_data  (w_tm),
        .o_valid (w_dt_valid),
        .i_ready (w_dt_ready),
        .o_data  (w_dt)
    );

    // Day of year -> month and date via eleven parallel compares; leap day handled
    // on its own, later leap-year days shifted back by one. Holds the output register.
    ectc_month_map u_month_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_dt_valid),
        .o_ready        (w_dt_ready),
        .i_data         (w_dt),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_second       (o_second),
        .o_minute       (o_minute),
        .o_hour         (o_hour),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month        (o_month),
        .o_year         (o_year)
    );

endmodule

// File: rtl/ectc_checker.sv
// Port-level checks for the calendar unit, bound to the top level.
module ectc_checker
    import ectc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_local_seconds,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_second,
    input logic [5:0]  o_minute,
    input logic [4:0]  o_hour,
    input logic [2:0]  o_weekday,
    input logic [4:0]  o_day_of_month,
    input logic [3:0]  o_month,
    input logic [7:0]  o_year
);

    // divide corrections keep time of day in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_second < 6'd60) && (o_minute < 6'd60) && (o_hour < 5'd24))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weekday != 3'd0) && (o_day_of_month != 5'd0)
                        && (o_month != 4'd0) && (o_month <= MONTHS_PER_YEAR))
        else $error("date field out of range");

    // February 29 only in a leap year
    a_feb_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_month == MONTH_FEB)) |->
            (o_day_of_month <= LEAP_DAY_DOM)
            && ((o_year[1:0] == 2'b00) || (o_day_of_month != LEAP_DAY_DOM)))
        else $error("bad February date");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid
            && $stable(o_second) && $stable(o_minute) && $stable(o_hour)
            && $stable(o_weekday) && $stable(o_day_of_month)
            && $stable(o_month) && $stable(o_year))
        else $error("result changed while stalled");

endmodule

bind epoch_seconds_to_calendar_unit ectc_checker u_ectc_checker (.*);

// File: tb/tb_epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the epoch-seconds to calendar-date pipeline.
module tb_epoch_seconds_to_calendar_unit;

    // Run limit in clock cycles. The slowest correct run is about 500 items,
    // each with an idle burst on the input and a stall burst on the
    // output, plus the pipeline depth. This limit is many times that.
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    // Drain this long after the last result.
    localparam int unsigned DRAIN_CYCLES = 20;
    // Idling stops once fewer than this many items are still waiting.
    localparam int unsigned CALM_TAIL    = 40;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned LEAP_DOY     = 60;
    localparam int unsigned FEBRUARY     = 2;
    localparam int unsigned MARCH        = 3;
    localparam int unsigned LEAP_DOM     = 29;

    // One calendar result, at the widths of the output ports.
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] year;
    } t_cal;

    // Clock, reset and block inputs, all known from time zero.
    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic [31:0] in_secs   = '0;
    logic        out_ready = 1'b1;

    // Block outputs.
    logic        in_ready;
    logic        out_valid;
    logic [5:0]  cal_second;
    logic [5:0]  cal_minute;
    logic [4:0]  cal_hour;
    logic [2:0]  cal_weekday;
    logic [4:0]  cal_dom;
    logic [3:0]  cal_month;
    logic [7:0]  cal_year;

    // Timestamps not yet presented, and dates owed by the block, oldest first.
    logic [31:0] pending_secs [$];
    t_cal        calendar_due [$];

    int unsigned mismatches   = 0;
    int unsigned dates_seen   = 0;
    int unsigned leap_days    = 0;
    int unsigned after_leap   = 0;
    int unsigned cycle_count  = 0;

    // Idle / stall bookkeeping for both sides.
    int unsigned drv_gap      = 0;
    int unsigned drv_stretch  = 0;
    bit          drv_idle_on  = 1'b0;
    int unsigned rcv_gap      = 0;
    int unsigned rcv_stretch  = 0;
    bit          rcv_stall_on = 1'b0;

    epoch_seconds_to_calendar_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_local_seconds (in_secs),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_second        (cal_second),
        .o_minute        (cal_minute),
        .o_hour          (cal_hour),
        .o_weekday       (cal_weekday),
        .o_day_of_month  (cal_dom),
        .o_month         (cal_month),
        .o_year          (cal_year)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected date for a timestamp. Plain integer arithmetic: split off the
    // time of day, then year by 4*days/1461 (every fourth year leap, no
    // century rule), then walk the month lengths. Feb 29 is pulled out first
    // and later days of a leap year are moved back one so Mar 1 lands right.
    function automatic t_cal calendar_of(input logic [31:0] stamp);
        t_cal        c;
        int unsigned t;
        int unsigned days;
        int unsigned yr;
        int unsigned doy;
        int unsigned mon;
        int unsigned mlen;
        bit          leap;
        t        = stamp;
        c.second = 6'(t % 60);
        t        = t / 60;
        c.minute = 6'(t % 60);
        t        = t / 60;
        c.hour   = 5'(t % 24);
        days     = t / 24;
        // weekday: remainder 0 reads as 7
        c.weekday = (days % 7 == 0) ? 3'd7 : 3'(days % 7);
        yr   = (4 * days) / 1461;
        doy  = days - (365 * yr + (yr + 3) / 4) + 1;
        leap = (yr % 4 == 0);
        if (leap && doy == LEAP_DOY) begin
            mon = FEBRUARY;
            doy = LEAP_DOM;
        end else begin
            if (leap && doy > LEAP_DOY) doy = doy - 1;
            mon = 1;
            mlen = 31;
            while (mon < 12 && doy > mlen) begin
                doy = doy - mlen;
                mon = mon + 1;
                case (mon)
                    2:       mlen = 28;
                    4, 6, 9, 11: mlen = 30;
                    default: mlen = 31;
                endcase
            end
        end
        c.day_of_month = 5'(doy);
        c.month        = 4'(mon);
        c.year         = 8'(yr);
        return c;
    endfunction

    // Timestamp of a given year (since 2000), zero-based day in that year and
    // second of day. Kept below 2^32 by the callers.
    function automatic logic [31:0] stamp_of(input int unsigned yr, input int unsigned day,
                                             input int unsigned tod);
        return 32'((365 * yr + (yr + 3) / 4 + day) * SECS_PER_DAY + tod);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver. An accepted transaction is predicted on the spot and its
    // date queued. When the channel is free, the next timestamp goes out
    // unless an idle burst is running or starting.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv_proc
        bit calm;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            calm = (pending_secs.size() < CALM_TAIL);
            if (in_valid && in_ready) begin
                calendar_due.push_back(calendar_of(in_secs));
            end
            // alternate stretches with and without idling
            if (drv_stretch == 0) begin
                drv_stretch = $urandom_range(20, 80);
                drv_idle_on = ($urandom_range(0, 2) != 0);
            end else begin
                drv_stretch--;
            end
            if (!in_valid || in_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    in_valid <= 1'b0;
                end else if (pending_secs.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!calm && drv_idle_on && $urandom_range(0, 3) == 0) begin
                    // burst of idle cycles, this one included
                    drv_gap = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_secs  <= pending_secs.pop_front();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready. Stall bursts, off in the tail of the run.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rcv_proc
        bit calm;
        if (!i_rst_n) begin
            out_ready <= 1'b1;
        end else begin
            calm = (pending_secs.size() < CALM_TAIL);
            if (rcv_stretch == 0) begin
                rcv_stretch  = $urandom_range(20, 80);
                rcv_stall_on = ($urandom_range(0, 2) != 0);
            end else begin
                rcv_stretch--;
            end
            if (rcv_gap > 0) begin
                rcv_gap--;
                out_ready <= 1'b0;
            end else if (!calm && rcv_stall_on && $urandom_range(0, 4) == 0) begin
                rcv_gap = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every output transaction against the oldest due date.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon_proc
        t_cal want;
        if (i_rst_n && out_valid && out_ready) begin
            if (calendar_due.size() == 0) begin
                $error("unexpected result: %0d-%0d-%0d %0d:%0d:%0d",
                       cal_year, cal_month, cal_dom, cal_hour, cal_minute, cal_second);
                mismatches++;
            end else begin
                want = calendar_due.pop_front();
                check_field("second",       want.second,       cal_second);
                check_field("minute",       want.minute,       cal_minute);
                check_field("hour",         want.hour,         cal_hour);
                check_field("weekday",      want.weekday,      cal_weekday);
                check_field("day_of_month", want.day_of_month, cal_dom);
                check_field("month",        want.month,        cal_month);
                check_field("year",         want.year,         cal_year);
                dates_seen++;
                if (want.month == FEBRUARY && want.day_of_month == LEAP_DOM) leap_days++;
                if (want.year % 4 == 0 && want.month >= MARCH) after_leap++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d dates still due",
                     cycle_count, calendar_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : stim_proc
        int unsigned kind;
        int unsigned yr;
        // Directed: field extremes, leap day and the day after it in leap and
        // common years, year ends, weekday wrap, alternating bit patterns and
        // the top of the input range.
        pending_secs.push_back(32'd0);
        pending_secs.push_back(32'd59);
        pending_secs.push_back(32'd60);
        pending_secs.push_back(32'd3599);
        pending_secs.push_back(32'd3600);
        pending_secs.push_back(32'd86399);
        pending_secs.push_back(32'd86400);
        pending_secs.push_back(stamp_of(0, 58, 0));         // Feb 28 2000
        pending_secs.push_back(stamp_of(0, 59, 12345));     // Feb 29 2000
        pending_secs.push_back(stamp_of(0, 60, 0));         // Mar 1 2000
        pending_secs.push_back(stamp_of(0, 365, 86399));    // Dec 31 2000, doy 366
        pending_secs.push_back(stamp_of(1, 0, 0));          // Jan 1 2001
        pending_secs.push_back(stamp_of(1, 58, 86399));     // Feb 28 2001
        pending_secs.push_back(stamp_of(1, 59, 0));         // Mar 1 2001
        pending_secs.push_back(stamp_of(3, 364, 86399));    // Dec 31 2003
        pending_secs.push_back(stamp_of(4, 59, 43200));     // Feb 29 2004
        pending_secs.push_back(stamp_of(132, 59, 0));       // last reachable Feb 29
        pending_secs.push_back(stamp_of(132, 365, 86399));
        pending_secs.push_back(32'(6 * SECS_PER_DAY));      // weekday 6
        pending_secs.push_back(32'(7 * SECS_PER_DAY));      // remainder 0 -> 7
        pending_secs.push_back(32'h8000_0000);
        pending_secs.push_back(32'h5555_5555);
        pending_secs.push_back(32'hAAAA_AAAA);
        pending_secs.push_back(32'hFFFF_FFFE);
        pending_secs.push_back(32'hFFFF_FFFF);

        // Random part, weighted toward month and year boundaries.
        repeat (475) begin
            kind = $urandom_range(0, 9);
            yr   = $urandom_range(0, 135);
            case (kind)
                0, 1, 2: pending_secs.push_back($urandom());
                3, 4, 5: pending_secs.push_back(
                             stamp_of(yr, $urandom_range(57, 61),
                                      $urandom_range(0, SECS_PER_DAY - 1)));
                6:       pending_secs.push_back(
                             stamp_of(yr, $urandom_range(363, 365),
                                      $urandom_range(0, SECS_PER_DAY - 1)));
                7:       pending_secs.push_back(32'hFFFF_FFFF - $urandom_range(0, 3_000_000));
                8:       pending_secs.push_back($urandom_range(0, 200_000));
                default: pending_secs.push_back(
                             stamp_of(yr, $urandom_range(0, 364),
                                      ($urandom_range(0, 1) != 0) ? SECS_PER_DAY - 1 : 0));
            endcase
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all timestamps handed over, then all dates back, then a quiet drain
        while (pending_secs.size() != 0 || in_valid) @(posedge i_clk);
        while (calendar_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d dates: %0d on Feb 29, %0d past Feb in leap years.",
                 dates_seen, leap_days, after_leap);
        $display("Input idles and output stalls in random bursts, quiet tail at the end.");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
